// ===== design/rcid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcid_pkg
// Shared widths, types and codes for the rectangular cell inverse-distance
// interpolator.
// ----------------------------------------------------------------------------
package rcid_pkg;

    localparam int COORD_WIDTH    = 20;
    localparam int VALUE_WIDTH    = 32;
    localparam int REG_WIDTH      = 19;
    localparam int CFG_ADDR_WIDTH = 2;

    localparam int EXT_WIDTH  = ((COORD_WIDTH > REG_WIDTH) ? COORD_WIDTH : REG_WIDTH) + 2;
    localparam int MAG_WIDTH  = EXT_WIDTH - 1;
    localparam int DIST_WIDTH = 2 * MAG_WIDTH + 1;

    localparam int WEIGHT_SHIFT = 60;
    localparam int WEIGHT_WIDTH = WEIGHT_SHIFT + 1;
    localparam int WLO_WIDTH    = 31;
    localparam int WHI_WIDTH    = WEIGHT_WIDTH - WLO_WIDTH;

    localparam int PROD_WIDTH  = VALUE_WIDTH + WEIGHT_WIDTH;
    localparam int ACC_WIDTH   = PROD_WIDTH + 2;
    localparam int WSUM_WIDTH  = WEIGHT_WIDTH + 2;
    localparam int NUM_WIDTH   = ACC_WIDTH + 1;
    localparam int DIV_WIDTH   = WSUM_WIDTH + 1;
    localparam int QUOT_WIDTH  = VALUE_WIDTH + 1;

    localparam logic [REG_WIDTH-1:0] CELL_RESET = REG_WIDTH'(256);

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        REG_CELL_WIDTH  = CFG_ADDR_WIDTH'(0),
        REG_CELL_HEIGHT = CFG_ADDR_WIDTH'(1)
    } reg_idx_t;

    typedef logic [3:0][VALUE_WIDTH-1:0]  vals_t;
    typedef logic [3:0][DIST_WIDTH-1:0]   dists_t;
    typedef logic [3:0][WEIGHT_WIDTH-1:0] weights_t;

    typedef struct packed {
        logic                   hit;
        logic [VALUE_WIDTH-1:0] hit_value;
    } side_t;

endpackage

// ===== design/rcid_dist.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcid_dist
// Three-stage squared distance from the query point to the four corners,
// with detection of a query on a corner.
// ----------------------------------------------------------------------------
module rcid_dist (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic [rcid_pkg::REG_WIDTH-1:0]       cell_width,
    input  logic [rcid_pkg::REG_WIDTH-1:0]       cell_height,
    input  logic signed [rcid_pkg::COORD_WIDTH-1:0] corner_x,
    input  logic signed [rcid_pkg::COORD_WIDTH-1:0] corner_y,
    input  logic signed [rcid_pkg::COORD_WIDTH-1:0] query_x,
    input  logic signed [rcid_pkg::COORD_WIDTH-1:0] query_y,
    input  rcid_pkg::vals_t                      in_vals,
    output logic                                 out_valid,
    output rcid_pkg::dists_t                     dists,
    output rcid_pkg::vals_t                      out_vals,
    output rcid_pkg::side_t                      side
);
    import rcid_pkg::*;

    logic                        s1_valid_reg;
    logic signed [EXT_WIDTH-1:0] dx0_reg, dx1_reg, dy0_reg, dy1_reg;
    logic signed [EXT_WIDTH-1:0] dx0_next, dx1_next, dy0_next, dy1_next;
    vals_t                       s1_vals_reg;

    logic                          s2_valid_reg;
    logic signed [2*EXT_WIDTH-1:0] sx0_reg, sx1_reg, sy0_reg, sy1_reg;
    vals_t                         s2_vals_reg;

    logic   s3_valid_reg;
    dists_t d_reg, d_next;
    vals_t  s3_vals_reg;
    side_t  side_reg, side_next;

    always_comb
    begin
        dx0_next = EXT_WIDTH'(query_x) - EXT_WIDTH'(corner_x);
        dy0_next = EXT_WIDTH'(query_y) - EXT_WIDTH'(corner_y);
        dx1_next = dx0_next - EXT_WIDTH'($signed({1'b0, cell_width}));
        dy1_next = dy0_next - EXT_WIDTH'($signed({1'b0, cell_height}));
    end

    always_comb
    begin
        d_next[0] = {1'b0, sx0_reg[2*MAG_WIDTH-1:0]} + {1'b0, sy0_reg[2*MAG_WIDTH-1:0]};
        d_next[1] = {1'b0, sx1_reg[2*MAG_WIDTH-1:0]} + {1'b0, sy0_reg[2*MAG_WIDTH-1:0]};
        d_next[2] = {1'b0, sx1_reg[2*MAG_WIDTH-1:0]} + {1'b0, sy1_reg[2*MAG_WIDTH-1:0]};
        d_next[3] = {1'b0, sx0_reg[2*MAG_WIDTH-1:0]} + {1'b0, sy1_reg[2*MAG_WIDTH-1:0]};
        side_next.hit       = 1'b0;
        side_next.hit_value = s2_vals_reg[0];
        for (int i = 3; i >= 0; i--)
        begin
            if (d_next[i] == '0)
            begin
                side_next.hit       = 1'b1;
                side_next.hit_value = s2_vals_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx0_reg     <= dx0_next;
        dx1_reg     <= dx1_next;
        dy0_reg     <= dy0_next;
        dy1_reg     <= dy1_next;
        s1_vals_reg <= in_vals;
        sx0_reg     <= dx0_reg * dx0_reg;
        sx1_reg     <= dx1_reg * dx1_reg;
        sy0_reg     <= dy0_reg * dy0_reg;
        sy1_reg     <= dy1_reg * dy1_reg;
        s2_vals_reg <= s1_vals_reg;
        d_reg       <= d_next;
        s3_vals_reg <= s2_vals_reg;
        side_reg    <= side_next;
    end

    assign out_valid = s3_valid_reg;
    assign dists     = d_reg;
    assign out_vals  = s3_vals_reg;
    assign side      = side_reg;

endmodule

// ===== design/rcid_recip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcid_recip
// Pipelined restoring divider, one quotient bit per stage: floor(2^60 / d).
// ----------------------------------------------------------------------------
module rcid_recip (
    input  logic                                clk,
    input  logic [rcid_pkg::DIST_WIDTH-1:0]     dist_sq,
    output logic [rcid_pkg::WEIGHT_WIDTH-1:0]   weight
);
    import rcid_pkg::*;

    logic [DIST_WIDTH-1:0]   d_reg   [0:WEIGHT_WIDTH-1];
    logic [DIST_WIDTH-1:0]   rem_reg [0:WEIGHT_WIDTH-1];
    logic [WEIGHT_WIDTH-1:0] q_reg   [0:WEIGHT_WIDTH-1];

    for (genvar s = 0; s < WEIGHT_WIDTH; s++)
    begin : g_stage
        logic [DIST_WIDTH-1:0]   d_in;
        logic [DIST_WIDTH:0]     trial;
        logic [WEIGHT_WIDTH-1:0] q_in;
        logic                    ge;

        if (s == 0)
        begin : g_first
            // numerator 2^60: its only set bit enters at the first stage
            assign d_in  = dist_sq;
            assign trial = (DIST_WIDTH+1)'(1);
            assign q_in  = '0;
        end
        else
        begin : g_rest
            assign d_in  = d_reg[s-1];
            assign trial = {rem_reg[s-1], 1'b0};
            assign q_in  = q_reg[s-1];
        end

        assign ge = (trial >= {1'b0, d_in});

        always_ff @(posedge clk)
        begin
            d_reg[s]   <= d_in;
            rem_reg[s] <= ge ? DIST_WIDTH'(trial - {1'b0, d_in}) : trial[DIST_WIDTH-1:0];
            q_reg[s]   <= {q_in[WEIGHT_WIDTH-2:0], ge};
        end
    end

    assign weight = q_reg[WEIGHT_WIDTH-1];

endmodule

// ===== design/rcid_wsum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcid_wsum
// Weighted sum of corner values and weight sum, split into partial
// products, then rounding numerator 2|n| + S.
// ----------------------------------------------------------------------------
module rcid_wsum (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  rcid_pkg::weights_t                 weights,
    input  rcid_pkg::vals_t                    vals,
    input  rcid_pkg::side_t                    in_side,
    output logic                               out_valid,
    output logic [rcid_pkg::NUM_WIDTH-1:0]     num,
    output logic [rcid_pkg::WSUM_WIDTH-1:0]    wsum,
    output logic                               negative,
    output rcid_pkg::side_t                    out_side
);
    import rcid_pkg::*;

    logic [5:0]  valid_reg;
    side_t       side_reg [0:5];
    logic [WSUM_WIDTH-1:0] ws_reg [0:5];
    logic [WSUM_WIDTH-1:0] ws_next;

    logic [3:0][VALUE_WIDTH-1:0]  mag_reg, mag_next;
    logic [3:0]                   sa_reg, sb_reg, sc_reg;
    weights_t                     wa_reg;
    logic [3:0][VALUE_WIDTH+WLO_WIDTH-1:0] plo_reg;
    logic [3:0][VALUE_WIDTH+WHI_WIDTH-1:0] phi_reg;
    logic [3:0][PROD_WIDTH-1:0]   p_reg;
    logic [ACC_WIDTH-1:0]         pos_reg, neg_reg, pos_next, neg_next;
    logic [ACC_WIDTH-1:0]         mag_acc_reg;
    logic                         negative_reg, negf_reg;
    logic [NUM_WIDTH-1:0]         num_reg;

    always_comb
    begin
        ws_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            mag_next[i] = vals[i][VALUE_WIDTH-1] ? (~vals[i] + 1'b1) : vals[i];
            ws_next     = ws_next + WSUM_WIDTH'(weights[i]);
        end
    end

    always_comb
    begin
        pos_next = '0;
        neg_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (sc_reg[i])
                neg_next = neg_next + ACC_WIDTH'(p_reg[i]);
            else
                pos_next = pos_next + ACC_WIDTH'(p_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[4:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        ws_reg[0]   <= ws_next;
        for (int k = 1; k < 6; k++)
        begin
            side_reg[k] <= side_reg[k-1];
            ws_reg[k]   <= ws_reg[k-1];
        end
        mag_reg <= mag_next;
        wa_reg  <= weights;
        for (int i = 0; i < 4; i++)
        begin
            sa_reg[i]  <= vals[i][VALUE_WIDTH-1];
            plo_reg[i] <= mag_reg[i] * wa_reg[i][WLO_WIDTH-1:0];
            phi_reg[i] <= mag_reg[i] * wa_reg[i][WEIGHT_WIDTH-1:WLO_WIDTH];
            p_reg[i]   <= PROD_WIDTH'(plo_reg[i])
                        + (PROD_WIDTH'(phi_reg[i]) << WLO_WIDTH);
        end
        sb_reg <= sa_reg;
        sc_reg <= sb_reg;
        pos_reg <= pos_next;
        neg_reg <= neg_next;
        negative_reg <= (pos_reg < neg_reg);
        mag_acc_reg  <= (pos_reg < neg_reg) ? (neg_reg - pos_reg) : (pos_reg - neg_reg);
        negf_reg     <= negative_reg;
        num_reg      <= {mag_acc_reg, 1'b0} + NUM_WIDTH'(ws_reg[4]);
    end

    assign out_valid = valid_reg[5];
    assign num       = num_reg;
    assign wsum      = ws_reg[5];
    assign negative  = negf_reg;
    assign out_side  = side_reg[5];

endmodule

// ===== design/rcid_qdiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcid_qdiv
// Pipelined restoring divider floor(num / 2S), one quotient bit per stage,
// sign restore and corner override into the result register.
// ----------------------------------------------------------------------------
module rcid_qdiv (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [rcid_pkg::NUM_WIDTH-1:0]     num,
    input  logic [rcid_pkg::WSUM_WIDTH-1:0]    wsum,
    input  logic                               negative,
    input  rcid_pkg::side_t                    in_side,
    output logic                               done,
    output logic [rcid_pkg::VALUE_WIDTH-1:0]   interpolated,
    output logic                               on_corner
);
    import rcid_pkg::*;

    logic [QUOT_WIDTH:0]   valid_reg;
    logic [DIV_WIDTH-1:0]  dv_reg  [0:QUOT_WIDTH];
    logic [DIV_WIDTH-1:0]  rem_reg [0:QUOT_WIDTH];
    logic [QUOT_WIDTH-1:0] low_reg [0:QUOT_WIDTH];
    logic [QUOT_WIDTH-1:0] q_reg   [0:QUOT_WIDTH];
    logic                  neg_reg [0:QUOT_WIDTH];
    side_t                 side_reg [0:QUOT_WIDTH];

    logic                   done_reg, on_corner_reg;
    logic [VALUE_WIDTH-1:0] interp_reg;
    logic [QUOT_WIDTH-1:0]  q_signed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[QUOT_WIDTH-1:0], in_valid};
            done_reg  <= valid_reg[QUOT_WIDTH];
        end
    end

    // quotient is known to fit QUOT_WIDTH bits, so the top bits seed the remainder
    always_ff @(posedge clk)
    begin
        dv_reg[0]   <= {wsum, 1'b0};
        rem_reg[0]  <= DIV_WIDTH'(num >> QUOT_WIDTH);
        low_reg[0]  <= num[QUOT_WIDTH-1:0];
        q_reg[0]    <= '0;
        neg_reg[0]  <= negative;
        side_reg[0] <= in_side;
    end

    for (genvar k = 1; k <= QUOT_WIDTH; k++)
    begin : g_stage
        logic [DIV_WIDTH:0] trial;
        logic               ge;

        assign trial = {rem_reg[k-1], low_reg[k-1][QUOT_WIDTH-k]};
        assign ge    = (trial >= {1'b0, dv_reg[k-1]});

        always_ff @(posedge clk)
        begin
            dv_reg[k]   <= dv_reg[k-1];
            rem_reg[k]  <= ge ? DIV_WIDTH'(trial - {1'b0, dv_reg[k-1]})
                              : trial[DIV_WIDTH-1:0];
            low_reg[k]  <= low_reg[k-1];
            q_reg[k]    <= {q_reg[k-1][QUOT_WIDTH-2:0], ge};
            neg_reg[k]  <= neg_reg[k-1];
            side_reg[k] <= side_reg[k-1];
        end
    end

    assign q_signed = neg_reg[QUOT_WIDTH] ? (~q_reg[QUOT_WIDTH] + 1'b1) : q_reg[QUOT_WIDTH];

    always_ff @(posedge clk)
    begin
        on_corner_reg <= side_reg[QUOT_WIDTH].hit;
        interp_reg    <= side_reg[QUOT_WIDTH].hit ? side_reg[QUOT_WIDTH].hit_value
                                                  : q_signed[VALUE_WIDTH-1:0];
    end

    assign done         = done_reg;
    assign interpolated = interp_reg;
    assign on_corner    = on_corner_reg;

endmodule

// ===== design/rect_cell_inverse_distance_interp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_cell_inverse_distance_interp
// Inverse-square-distance weighted mean of four cell corner values.
// ----------------------------------------------------------------------------
// channel   signals                              handshake
// input     corner_*, query_*, value_*           start && !busy
// result    interpolated, on_corner              done, one cycle
// config    cfg_we, cfg_addr, cfg_wdata          cfg_we
//
// One transaction per cycle; results pass through the distance stages, the
// one-bit-per-stage reciprocal dividers, the weighted sum and the final divider.
// busy is never raised. Reset clears valid bits and sets both cell sizes
// to 256. The result side cannot stall; results leave in input order.
// ----------------------------------------------------------------------------
module rect_cell_inverse_distance_interp (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    cfg_we,
    input  logic [rcid_pkg::CFG_ADDR_WIDTH-1:0]     cfg_addr,
    input  logic [rcid_pkg::REG_WIDTH-1:0]          cfg_wdata,
    input  logic signed [rcid_pkg::COORD_WIDTH-1:0] corner_x,
    input  logic signed [rcid_pkg::COORD_WIDTH-1:0] corner_y,
    input  logic signed [rcid_pkg::COORD_WIDTH-1:0] query_x,
    input  logic signed [rcid_pkg::COORD_WIDTH-1:0] query_y,
    input  logic signed [rcid_pkg::VALUE_WIDTH-1:0] value_lower_left,
    input  logic signed [rcid_pkg::VALUE_WIDTH-1:0] value_lower_right,
    input  logic signed [rcid_pkg::VALUE_WIDTH-1:0] value_upper_right,
    input  logic signed [rcid_pkg::VALUE_WIDTH-1:0] value_upper_left,
    output logic                                    done,
    output logic signed [rcid_pkg::VALUE_WIDTH-1:0] interpolated,
    output logic                                    on_corner
);
    import rcid_pkg::*;

    logic [REG_WIDTH-1:0] cell_width_reg, cell_height_reg;
    logic                 accept;
    vals_t                in_vals;

    logic   dist_valid;
    dists_t dists;
    vals_t  dist_vals;
    side_t  dist_side;

    weights_t weights;

    logic [WEIGHT_WIDTH-1:0] dl_valid_reg;
    vals_t                   dl_vals_reg [0:WEIGHT_WIDTH-1];
    side_t                   dl_side_reg [0:WEIGHT_WIDTH-1];

    logic                  ws_valid;
    logic [NUM_WIDTH-1:0]  ws_num;
    logic [WSUM_WIDTH-1:0] ws_sum;
    logic                  ws_negative;
    side_t                 ws_side;
    logic [VALUE_WIDTH-1:0] interp_u;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign in_vals = {value_upper_left, value_upper_right, value_lower_right, value_lower_left};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_width_reg  <= CELL_RESET;
            cell_height_reg <= CELL_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_CELL_WIDTH:  cell_width_reg  <= cfg_wdata;
                REG_CELL_HEIGHT: cell_height_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    rcid_dist u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .cell_width  (cell_width_reg),
        .cell_height (cell_height_reg),
        .corner_x    (corner_x),
        .corner_y    (corner_y),
        .query_x     (query_x),
        .query_y     (query_y),
        .in_vals     (in_vals),
        .out_valid   (dist_valid),
        .dists       (dists),
        .out_vals    (dist_vals),
        .side        (dist_side)
    );

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        rcid_recip u_recip (
            .clk     (clk),
            .dist_sq (dists[i]),
            .weight  (weights[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dl_valid_reg <= '0;
        else
            dl_valid_reg <= {dl_valid_reg[WEIGHT_WIDTH-2:0], dist_valid};
    end

    always_ff @(posedge clk)
    begin
        dl_vals_reg[0] <= dist_vals;
        dl_side_reg[0] <= dist_side;
        for (int k = 1; k < WEIGHT_WIDTH; k++)
        begin
            dl_vals_reg[k] <= dl_vals_reg[k-1];
            dl_side_reg[k] <= dl_side_reg[k-1];
        end
    end

    rcid_wsum u_wsum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dl_valid_reg[WEIGHT_WIDTH-1]),
        .weights   (weights),
        .vals      (dl_vals_reg[WEIGHT_WIDTH-1]),
        .in_side   (dl_side_reg[WEIGHT_WIDTH-1]),
        .out_valid (ws_valid),
        .num       (ws_num),
        .wsum      (ws_sum),
        .negative  (ws_negative),
        .out_side  (ws_side)
    );

    rcid_qdiv u_qdiv (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (ws_valid),
        .num          (ws_num),
        .wsum         (ws_sum),
        .negative     (ws_negative),
        .in_side      (ws_side),
        .done         (done),
        .interpolated (interp_u),
        .on_corner    (on_corner)
    );

    assign interpolated = $signed(interp_u);

endmodule

// ===== tb/sv/rcid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcid_checker
// Watches the input, config and result channels of the inverse-distance cell
// interpolator. It predicts each result from its own copy of the cell size
// registers and compares the results in order, field by field.
// ----------------------------------------------------------------------------
module rcid_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic                                    busy,
    input  logic                                    cfg_we,
    input  logic [rcid_pkg::CFG_ADDR_WIDTH-1:0]     cfg_addr,
    input  logic [rcid_pkg::REG_WIDTH-1:0]          cfg_wdata,
    input  logic signed [rcid_pkg::COORD_WIDTH-1:0] corner_x,
    input  logic signed [rcid_pkg::COORD_WIDTH-1:0] corner_y,
    input  logic signed [rcid_pkg::COORD_WIDTH-1:0] query_x,
    input  logic signed [rcid_pkg::COORD_WIDTH-1:0] query_y,
    input  logic signed [rcid_pkg::VALUE_WIDTH-1:0] value_lower_left,
    input  logic signed [rcid_pkg::VALUE_WIDTH-1:0] value_lower_right,
    input  logic signed [rcid_pkg::VALUE_WIDTH-1:0] value_upper_right,
    input  logic signed [rcid_pkg::VALUE_WIDTH-1:0] value_upper_left,
    input  logic                                    done,
    input  logic signed [rcid_pkg::VALUE_WIDTH-1:0] interpolated,
    input  logic                                    on_corner,
    output int                                      fail_count,
    output int                                      pending
);
    import rcid_pkg::*;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] mean;
        logic                   hit;
    } mean_t;

    mean_t                 expected_means[$];
    logic [REG_WIDTH-1:0]  width_q;
    logic [REG_WIDTH-1:0]  height_q;
    int                    result_no;

    assign pending = expected_means.size();

    function automatic longint unsigned sq_dist(longint ex, longint ey);
        longint unsigned ax;
        longint unsigned ay;
        ax = (ex < 0) ? longint'(-ex) : ex;
        ay = (ey < 0) ? longint'(-ey) : ey;
        return ax * ax + ay * ay;
    endfunction

    function automatic mean_t idw_mean(vals_t v, logic [REG_WIDTH-1:0] cw,
                                       logic [REG_WIDTH-1:0] ch);
        longint            ex0, ex1, ey0, ey1, vi;
        longint unsigned   d[4];
        longint unsigned   w;
        longint unsigned   wsum;
        logic [127:0]      pos, neg, num, twice, q;
        bit                negative;
        mean_t             r;
        ex0  = longint'(query_x) - longint'(corner_x);
        ex1  = ex0 - longint'(cw);
        ey0  = longint'(query_y) - longint'(corner_y);
        ey1  = ey0 - longint'(ch);
        d[0] = sq_dist(ex0, ey0);
        d[1] = sq_dist(ex1, ey0);
        d[2] = sq_dist(ex1, ey1);
        d[3] = sq_dist(ex0, ey1);
        for (int i = 0; i < 4; i++)
        begin
            if (d[i] == 0)
            begin
                r.mean = v[i];
                r.hit  = 1'b1;
                return r;
            end
        end
        wsum = 0;
        pos  = '0;
        neg  = '0;
        for (int i = 0; i < 4; i++)
        begin
            w    = (64'd1 << WEIGHT_SHIFT) / d[i];
            wsum = wsum + w;
            vi   = longint'($signed(v[i]));
            if (vi < 0)
                neg = neg + 128'(longint'(-vi)) * 128'(w);
            else
                pos = pos + 128'(vi) * 128'(w);
        end
        negative = pos < neg;
        num      = negative ? neg - pos : pos - neg;
        twice    = (num << 1) + 128'(wsum);
        q        = twice / (128'(wsum) << 1);
        if (negative)
            q = -q;
        r.mean = q[VALUE_WIDTH-1:0];
        r.hit  = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [VALUE_WIDTH-1:0] got,
                                   logic [VALUE_WIDTH-1:0] want);
        $display("%0t: result %0d %s mismatch: got %0h expected %0h",
                 $realtime, result_no, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        result_no  = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        mean_t e;
        vals_t v;
        if (!rst_n)
        begin
            width_q  <= CELL_RESET;
            height_q <= CELL_RESET;
        end
        else
        begin
            if (start && !busy)
            begin
                v = {value_upper_left, value_upper_right, value_lower_right,
                     value_lower_left};
                expected_means.push_back(idw_mean(v, width_q, height_q));
            end
            if (done)
            begin
                if (expected_means.size() == 0)
                begin
                    $display("%0t: unexpected result %0h", $realtime, interpolated);
                    fail_count++;
                end
                else
                begin
                    e = expected_means.pop_front();
                    if (interpolated !== e.mean)
                        report_mismatch("interpolated", interpolated, e.mean);
                    if (on_corner !== e.hit)
                        report_mismatch("on_corner", VALUE_WIDTH'(on_corner),
                                        VALUE_WIDTH'(e.hit));
                end
                result_no++;
            end
            if (cfg_we && cfg_addr == REG_CELL_WIDTH)
                width_q <= cfg_wdata;
            if (cfg_we && cfg_addr == REG_CELL_HEIGHT)
                height_q <= cfg_wdata;
        end
    end

endmodule

// ===== tb/sv/tb_rect_cell_inverse_distance_interp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rect_cell_inverse_distance_interp
// Drives directed and random cell queries through several cell size settings
// and sender idle rates; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_rect_cell_inverse_distance_interp;
    import rcid_pkg::*;

    localparam logic [CFG_ADDR_WIDTH-1:0] REG_SPARE = CFG_ADDR_WIDTH'(3);
    localparam int REG_MAX     = (1 << REG_WIDTH) - 1;
    localparam int LATENCY     = 105;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASES      = 6;
    localparam int PER_PHASE   = 290;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic                          cfg_we = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0]     cfg_addr = '0;
    logic [REG_WIDTH-1:0]          cfg_wdata = '0;
    logic signed [COORD_WIDTH-1:0] corner_x = '0;
    logic signed [COORD_WIDTH-1:0] corner_y = '0;
    logic signed [COORD_WIDTH-1:0] query_x = '0;
    logic signed [COORD_WIDTH-1:0] query_y = '0;
    logic signed [VALUE_WIDTH-1:0] value_lower_left = '0;
    logic signed [VALUE_WIDTH-1:0] value_lower_right = '0;
    logic signed [VALUE_WIDTH-1:0] value_upper_right = '0;
    logic signed [VALUE_WIDTH-1:0] value_upper_left = '0;
    logic                          done;
    logic signed [VALUE_WIDTH-1:0] interpolated;
    logic                          on_corner;
    int                            fail_count;
    int                            pending;
    int                            idle_pct;
    int                            stall_cycles;
    logic [REG_WIDTH-1:0]          cur_w = CELL_RESET;
    logic [REG_WIDTH-1:0]          cur_h = CELL_RESET;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    rect_cell_inverse_distance_interp dut (.*);

    rcid_checker chk (.*);

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_rect_cell_inverse_distance_interp failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_ADDR_WIDTH-1:0] idx, logic [REG_WIDTH-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_CELL_WIDTH)
            cur_w = val;
        if (idx == REG_CELL_HEIGHT)
            cur_h = val;
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic send_query(logic [COORD_WIDTH-1:0] cx, logic [COORD_WIDTH-1:0] cy,
                              logic [COORD_WIDTH-1:0] qx, logic [COORD_WIDTH-1:0] qy,
                              vals_t v);
        logic b;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        corner_x          <= cx;
        corner_y          <= cy;
        query_x           <= qx;
        query_y           <= qy;
        value_lower_left  <= v[0];
        value_lower_right <= v[1];
        value_upper_right <= v[2];
        value_upper_left  <= v[3];
        start             <= 1'b1;
        forever
        begin
            @(negedge clk);
            b = busy;
            @(posedge clk);
            if (!b)
                break;
        end
    endtask

    function automatic logic [VALUE_WIDTH-1:0] rand_value();
        case ($urandom_range(7))
            0: return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
            1: return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
            2: return VALUE_WIDTH'($urandom_range(0, 20)) - VALUE_WIDTH'(10);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_query;
        logic [COORD_WIDTH-1:0] cx, cy, qx, qy;
        vals_t                  v;
        int                     r;
        for (int i = 0; i < 4; i++)
            v[i] = rand_value();
        cx = COORD_WIDTH'($urandom);
        cy = COORD_WIDTH'($urandom);
        r  = int'($urandom_range(9));
        if (r < 6)
        begin
            qx = cx + COORD_WIDTH'($urandom_range(0, cur_w));
            qy = cy + COORD_WIDTH'($urandom_range(0, cur_h));
        end
        else if (r == 6)
        begin
            qx = cx + ($urandom_range(1) ? COORD_WIDTH'(cur_w) : '0);
            qy = cy + ($urandom_range(1) ? COORD_WIDTH'(cur_h) : '0);
        end
        else if (r == 7)
        begin
            qx = cx + COORD_WIDTH'($urandom_range(0, 4)) - COORD_WIDTH'(2);
            qy = cy + COORD_WIDTH'(cur_h) + COORD_WIDTH'($urandom_range(0, 2))
               - COORD_WIDTH'(1);
        end
        else
        begin
            qx = COORD_WIDTH'($urandom);
            qy = COORD_WIDTH'($urandom);
        end
        send_query(cx, cy, qx, qy, v);
    endtask

    task automatic directed_queries;
        vals_t v;
        logic [COORD_WIDTH-1:0] mn, mx;
        mn = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        mx = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        v  = {32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff};
        send_query('0, '0, '0, '0, v);
        send_query('0, '0, COORD_WIDTH'(cur_w), '0, v);
        send_query('0, '0, COORD_WIDTH'(cur_w), COORD_WIDTH'(cur_h), v);
        send_query('0, '0, '0, COORD_WIDTH'(cur_h), v);
        send_query(mn, mn, mx, mx, v);
        send_query(mx, mx, mn, mn, v);
        send_query(mn, mx, mx, mn, {4{32'h8000_0000}});
        send_query(mx, mn, mn, mx, {4{32'h7fff_ffff}});
        send_query('0, '0, COORD_WIDTH'(cur_w >> 1), COORD_WIDTH'(cur_h >> 1), v);
        send_query('0, '0, 20'd1, 20'd1, {32'd3, 32'd0, 32'd0, 32'd0});
        send_query('0, '0, 20'd1, 20'd1, {-32'sd3, 32'd0, 32'd0, 32'd0});
        send_query('0, '0, 20'd1, '0, {32'd0, 32'd1, 32'd0, 32'd0});
        send_query(20'h12345, 20'hedcba, 20'h12346, 20'hedcbb, {32'h5555_5555,
                   32'haaaa_aaaa, 32'h0f0f_0f0f, 32'hf0f0_f0f0});
    endtask

    initial
    begin
        idle_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_queries();
        drain();
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0: ;
                1:
                begin
                    write_reg(REG_CELL_WIDTH, REG_WIDTH'(1));
                    write_reg(REG_CELL_HEIGHT, REG_WIDTH'(1));
                end
                2:
                begin
                    write_reg(REG_CELL_WIDTH, REG_WIDTH'(REG_MAX));
                    write_reg(REG_CELL_HEIGHT, REG_WIDTH'(REG_MAX));
                end
                3:
                begin
                    write_reg(REG_CELL_WIDTH, REG_WIDTH'(0));
                    write_reg(REG_CELL_HEIGHT, REG_WIDTH'($urandom_range(1, 1000)));
                    write_reg(REG_SPARE, REG_WIDTH'($urandom));
                end
                4:
                begin
                    write_reg(REG_CELL_WIDTH, REG_WIDTH'($urandom));
                    write_reg(REG_CELL_HEIGHT, REG_WIDTH'(0));
                end
                default:
                begin
                    write_reg(REG_CELL_WIDTH, REG_WIDTH'($urandom_range(1, 4096)));
                    write_reg(REG_CELL_HEIGHT, REG_WIDTH'($urandom_range(1, 4096)));
                end
            endcase
            if (p == 3)
                directed_queries();
            for (int i = 0; i < PER_PHASE; i++)
            begin
                if (i % 73 == 0)
                    idle_pct = (i / 73 % 3 == 0) ? 0 : (i / 73 % 3 == 1) ? 75 : 38;
                if (i == PER_PHASE / 2)
                    drain();
                random_query();
            end
        end
        drain();
        repeat (LATENCY + 20) @(posedge clk);
        if (fail_count == 0)
            $display("tb_rect_cell_inverse_distance_interp passed");
        else
            $display("tb_rect_cell_inverse_distance_interp failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/rcid_pkg.sv
design/rcid_dist.sv
design/rcid_recip.sv
design/rcid_wsum.sv
design/rcid_qdiv.sv
design/rect_cell_inverse_distance_interp.sv
tb/sv/rcid_checker.sv
tb/sv/tb_rect_cell_inverse_distance_interp.sv
